[src/tfdsa_pkg.sv]
// Package for the tagged fixnum divide/shift ALU.
// Holds command and status codes, widths and the front-to-back kind enum.
package tfdsa_pkg;

  localparam int unsigned TagBitsDef  = 3;
  localparam int unsigned WordBitsDef = 64;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned StatusW     = 2;

  localparam logic [CmdW-1:0] CmdQuot  = 3'd0;
  localparam logic [CmdW-1:0] CmdRem   = 3'd1;
  localparam logic [CmdW-1:0] CmdMod   = 3'd2;
  localparam logic [CmdW-1:0] CmdAnd   = 3'd3;
  localparam logic [CmdW-1:0] CmdIor   = 3'd4;
  localparam logic [CmdW-1:0] CmdXor   = 3'd5;
  localparam logic [CmdW-1:0] CmdShift = 3'd6;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StTypeErr = 2'd1;
  localparam logic [StatusW-1:0] StDivZero = 2'd2;

  typedef enum logic [1:0] {
    KindDone,
    KindDiv,
    KindShift
  } kind_e;

endpackage

[src/tfdsa_front.sv]
// Front end: accepts words, checks tags, untags operands and classifies them; computes bitwise results itself.
// Depends on tfdsa_pkg.
module tfdsa_front #(
  parameter int unsigned TagBits  = tfdsa_pkg::TagBitsDef,
  parameter int unsigned WordBits = tfdsa_pkg::WordBitsDef
) (
  input  logic [tfdsa_pkg::CmdW-1:0]    cmd_i,
  input  logic [WordBits-1:0]           a_i,
  input  logic [WordBits-1:0]           b_i,
  output tfdsa_pkg::kind_e              kind_o,
  output logic [tfdsa_pkg::CmdW-1:0]    cmd_o,
  output logic [WordBits-1:0]           x_o,
  output logic [WordBits-1:0]           y_o,
  output logic [WordBits-1:0]           res_o,
  output logic [tfdsa_pkg::StatusW-1:0] st_o
);
  import tfdsa_pkg::*;

  logic tag_bad, y_zero;

  always_comb begin
    tag_bad = |(a_i[TagBits-1:0] | b_i[TagBits-1:0]);
    x_o     = WordBits'($signed(a_i) >>> TagBits);
    y_o     = WordBits'($signed(b_i) >>> TagBits);
    y_zero  = (y_o == '0);
    cmd_o   = cmd_i;
    kind_o  = KindDone;
    res_o   = '0;
    st_o    = StOk;
    if (tag_bad) begin
      st_o = StTypeErr;
    end else begin
      case (cmd_i)
        CmdQuot, CmdRem, CmdMod: begin
          if (y_zero) st_o = StDivZero;
          else kind_o = KindDiv;
        end
        CmdAnd:   res_o = a_i & b_i;
        CmdIor:   res_o = a_i | b_i;
        CmdXor:   res_o = a_i ^ b_i;
        CmdShift: kind_o = KindShift;
        default:  res_o = '0;
      endcase
    end
  end
endmodule

[src/tfdsa_back.sv]
// Back end: pipelined restoring divider (one quotient bit per stage) and shifter.
// Depends on tfdsa_pkg; one item enters per cycle while en_i is high.
module tfdsa_back #(
  parameter int unsigned TagBits  = tfdsa_pkg::TagBitsDef,
  parameter int unsigned WordBits = tfdsa_pkg::WordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  tfdsa_pkg::kind_e              kind_i,
  input  logic [tfdsa_pkg::CmdW-1:0]    cmd_i,
  input  logic [WordBits-1:0]           x_i,
  input  logic [WordBits-1:0]           y_i,
  input  logic [WordBits-1:0]           res_i,
  input  logic [tfdsa_pkg::StatusW-1:0] st_i,
  output logic                          valid_o,
  output logic [WordBits-1:0]           res_o,
  output logic [tfdsa_pkg::StatusW-1:0] st_o
);
  import tfdsa_pkg::*;

  localparam int unsigned N  = WordBits;
  localparam int unsigned SW = $clog2(WordBits) + 1;

  logic [N:0]         vld_q;
  kind_e              kind_q [N+1];
  logic [CmdW-1:0]    cmd_q  [N+1];
  logic [N-1:0]       rem_q  [N+1];
  logic [N-1:0]       quo_q  [N+1];
  logic [N-1:0]       dvs_q  [N+1];
  logic               sx_q   [N+1];
  logic               sy_q   [N+1];
  logic [N-1:0]       yraw_q [N+1];
  logic [N-1:0]       res_q  [N+1];
  logic [StatusW-1:0] st_q   [N+1];

  logic [N-1:0] sh_res, ax, ay;
  logic [N-1:0] ycap;
  logic         y_neg, y_big;

  always_comb begin
    ax    = x_i[N-1] ? (~x_i + 1'b1) : x_i;
    ay    = y_i[N-1] ? (~y_i + 1'b1) : y_i;
    y_neg = y_i[N-1];
    ycap  = ay;
    y_big = (ay >= N'(N)) || (ay[N-1] && !y_neg);
    if (y_big) sh_res = y_neg ? {N{x_i[N-1]}} : '0;
    else if (y_neg) sh_res = N'($signed(x_i) >>> ycap[SW-1:0]);
    else sh_res = x_i << ycap[SW-1:0];
    if (y_big && !y_neg) sh_res = '0;
    else sh_res = sh_res << TagBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[N-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q[0] <= kind_i;
      cmd_q[0]  <= cmd_i;
      rem_q[0]  <= '0;
      quo_q[0]  <= ax;
      dvs_q[0]  <= ay;
      sx_q[0]   <= x_i[N-1];
      sy_q[0]   <= y_i[N-1];
      yraw_q[0] <= y_i;
      res_q[0]  <= (kind_i == KindShift) ? sh_res : res_i;
      st_q[0]   <= st_i;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [N:0]   trial;
    logic [N-1:0] r_sh;
    always_comb begin
      r_sh  = {rem_q[s][N-2:0], quo_q[s][N-1]};
      trial = {1'b0, r_sh} - {1'b0, dvs_q[s]};
      if (rem_q[s][N-1]) trial[N] = 1'b0;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        kind_q[s+1] <= kind_q[s];
        cmd_q[s+1]  <= cmd_q[s];
        dvs_q[s+1]  <= dvs_q[s];
        sx_q[s+1]   <= sx_q[s];
        sy_q[s+1]   <= sy_q[s];
        yraw_q[s+1] <= yraw_q[s];
        res_q[s+1]  <= res_q[s];
        st_q[s+1]   <= st_q[s];
        rem_q[s+1]  <= trial[N] ? r_sh : trial[N-1:0];
        quo_q[s+1]  <= {quo_q[s][N-2:0], ~trial[N]};
      end
    end
  end

  logic [N-1:0] q, r, m, v;
  logic         vout_q;
  logic [N-1:0] rout_q;
  logic [StatusW-1:0] sout_q;

  always_comb begin
    q = (sx_q[N] ^ sy_q[N]) ? (~quo_q[N] + 1'b1) : quo_q[N];
    r = sx_q[N] ? (~rem_q[N] + 1'b1) : rem_q[N];
    m = ((r != '0) && (r[N-1] != sy_q[N])) ? (r + yraw_q[N]) : r;
    case (cmd_q[N])
      CmdQuot: v = q;
      CmdRem:  v = r;
      default: v = m;
    endcase
    if (kind_q[N] == KindDiv) v = v << TagBits;
    else v = res_q[N];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vout_q <= 1'b0;
    else if (en_i) vout_q <= vld_q[N];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rout_q <= v;
      sout_q <= st_q[N];
    end
  end

  assign valid_o = vout_q;
  assign res_o   = rout_q;
  assign st_o    = sout_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && vld_q[N] |=> valid_o)
    else $error("back pipe lost item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && st_o != StOk |-> res_o == '0)
    else $error("nonzero result with error status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q))
    else $error("pipe moved while stalled");
endmodule

[src/tfdsa_queue.sv]
// Output queue: holds back-end results so the pipe may run ahead of tready.
// Uses no package; a circular buffer of Depth entries with an occupancy count.
module tfdsa_queue #(
  parameter int unsigned Width = 66,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign data_o  = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CW'(Depth) |-> !push_i || pop_i)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
endmodule

[src/tagged_fixnum_divide_shift_alu_core.sv]
// Top level of the tagged fixnum divide/shift ALU.
// Depends on tfdsa_pkg, tfdsa_front, tfdsa_back, tfdsa_queue.
//
// channel | dir | tdata fields (low bit up)           | tuser
// s_axis  | in  | operand_a[63:0], operand_b[127:64]  | cmd[2:0]
// m_axis  | out | result_word[63:0], status[65:64]    | none
//
// One word per cycle while the pipe advances; each word passes through
// the one-bit-per-stage divider pipe. The pipe advances while the output
// queue has a free slot or pops in the same cycle; otherwise the whole
// pipe and s_axis_tready hold.
// Reset clears valid bits, queue pointers and counters only.
module tagged_fixnum_divide_shift_alu_core #(
  parameter int unsigned TAG_BITS  = tfdsa_pkg::TagBitsDef,
  parameter int unsigned WORD_BITS = tfdsa_pkg::WordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [2*WORD_BITS-1:0]     s_axis_tdata,  // operand_a, operand_b
  input  logic [tfdsa_pkg::CmdW-1:0] s_axis_tuser,  // cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // result_word, status, zero pad
  output logic [((WORD_BITS + tfdsa_pkg::StatusW + 7) / 8) * 8-1:0] m_axis_tdata
);
  import tfdsa_pkg::*;

  localparam int unsigned OutW  = ((WORD_BITS + StatusW + 7) / 8) * 8;
  localparam int unsigned QW    = WORD_BITS + StatusW;
  localparam int unsigned QD    = 4;
  localparam int unsigned Lat   = WORD_BITS + 2;
  localparam int unsigned CW    = $clog2(QD + 1);

  kind_e              f_kind;
  logic [CmdW-1:0]    f_cmd;
  logic [WORD_BITS-1:0] f_x, f_y, f_res, b_res;
  logic [StatusW-1:0] f_st, b_st;
  logic               b_valid, en, q_empty, pop;
  logic [QW-1:0]      q_data;
  logic [CW-1:0]      q_cnt;
  logic [$clog2(Lat+QD+1)-1:0] inflight_q;

  tfdsa_front #(.TagBits(TAG_BITS), .WordBits(WORD_BITS)) u_front (
    .cmd_i (s_axis_tuser),
    .a_i   (s_axis_tdata[WORD_BITS-1:0]),
    .b_i   (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
    .kind_o(f_kind), .cmd_o(f_cmd), .x_o(f_x), .y_o(f_y),
    .res_o (f_res),  .st_o(f_st)
  );

  // advance the pipe only while the queue has a free slot for its exit word or pops
  assign pop = m_axis_tready && !q_empty;
  assign en  = (q_cnt < CW'(QD - 1)) || pop || (q_cnt == CW'(QD - 1));
  assign s_axis_tready = en;

  tfdsa_back #(.TagBits(TAG_BITS), .WordBits(WORD_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid && s_axis_tready),
    .kind_i(f_kind), .cmd_i(f_cmd), .x_i(f_x), .y_i(f_y),
    .res_i(f_res), .st_i(f_st),
    .valid_o(b_valid), .res_o(b_res), .st_o(b_st)
  );

  tfdsa_queue #(.Width(QW), .Depth(QD)) u_queue (
    .clk_i, .rst_ni,
    .push_i (b_valid && en),
    .data_i ({b_st, b_res}),
    .pop_i  (pop),
    .data_o (q_data),
    .empty_o(q_empty),
    .count_o(q_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= '0;
    else inflight_q <= inflight_q + ($bits(inflight_q))'(s_axis_tvalid && s_axis_tready)
                       - ($bits(inflight_q))'(pop);
  end

  assign m_axis_tvalid = !q_empty;
  assign m_axis_tdata  = OutW'(q_data);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt == CW'(QD) |-> !(b_valid && en) || pop)
    else $error("exit word dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == '0 |-> q_empty)
    else $error("word out without word in");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped");
endmodule
